/* design/ots_pkg.sv */
// Shared codes and constants for the odometry turn sequencer.
package ots_pkg;

	// Input word action codes.
	localparam logic [1:0] ACT_TICK      = 2'd0;
	localparam logic [1:0] ACT_START_CNT = 2'd1;
	localparam logic [1:0] ACT_START_DEG = 2'd2;
	localparam logic [1:0] ACT_STOP      = 2'd3;

	// Sequence phase codes.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_STOP_WAIT = 3'd1;
	localparam logic [2:0] PH_RST_CHECK = 3'd2;
	localparam logic [2:0] PH_PAUSE     = 3'd3;
	localparam logic [2:0] PH_DRIVE     = 3'd4;
	localparam logic [2:0] PH_TURNING   = 3'd5;
	localparam logic [2:0] PH_SETTLE    = 3'd6;
	localparam logic [2:0] PH_RELEASE   = 3'd7;

	// Configuration register indexes.
	localparam logic CFG_HALF_TURN = 1'b0;
	localparam logic CFG_FWD_SPEED = 1'b1;

	// Wait counters saturate at their full value.
	localparam int SETTLE_W = 8;
	localparam int PAUSE_W  = 7;
	localparam logic [SETTLE_W-1:0] SETTLE_FULL = 8'hFF;
	localparam logic [PAUSE_W-1:0]  PAUSE_FULL  = 7'h7F;

	// Ticks after the turn before line following is released.
	localparam logic [SETTLE_W-1:0] AFTER_TURN_TICKS = 8'd100;

	// Odometer magnitude under which the reset counts as confirmed.
	localparam int RESET_NEAR_ZERO = 50;

	// Division by 180 done as (x >> 2) / 45 with an exact reciprocal:
	// MULT = ceil(2^35 / 45), valid for any 30-bit dividend.
	localparam int DIV_X_W = 30;
	localparam int DIV_SHIFT = 35;
	localparam logic [29:0] DIV_MULT = 30'd763549742;

endpackage

/* design/ots_if.sv */
// Handshake channels for the turn sequencer: command words in, result words out.
interface ots_cmd_if #(
	parameter int ODO_WIDTH = 24
);
	logic                        valid;
	logic                        ready;
	logic [1:0]                  action;
	logic signed [15:0]          turn_amount;
	logic [15:0]                 turn_speed;
	logic signed [15:0]          commanded_speed;
	logic signed [ODO_WIDTH-1:0] left_odometer;

	modport source (
		output valid, action, turn_amount, turn_speed, commanded_speed, left_odometer,
		input  ready
	);
	modport sink (
		input  valid, action, turn_amount, turn_speed, commanded_speed, left_odometer,
		output ready
	);
endinterface

interface ots_res_if;
	logic               valid;
	logic               ready;
	logic               angular_write;
	logic signed [16:0] angular_goal;
	logic               linear_write;
	logic signed [15:0] linear_goal;
	logic               go_hold;
	logic               go_release;
	logic               odometer_reset;
	logic               busy_res;
	logic               start_rejected;
	logic [2:0]         phase;

	modport source (
		output valid, angular_write, angular_goal, linear_write, linear_goal, go_hold,
		       go_release, odometer_reset, busy_res, start_rejected, phase,
		input  ready
	);
	modport sink (
		input  valid, angular_write, angular_goal, linear_write, linear_goal, go_hold,
		       go_release, odometer_reset, busy_res, start_rejected, phase,
		output ready
	);
endinterface

/* design/ots_target.sv */
// Turn target: count as given or degrees times half-turn count / 180, saturated.
module ots_target #(
	parameter int ODO_WIDTH = 24
) (
	input  logic                 by_degrees,
	input  logic [15:0]          mag,
	input  logic [31:0]          product,
	output logic [ODO_WIDTH-2:0] target
);

	localparam logic [31:0] ODO_MAX = (32'd1 << (ODO_WIDTH - 1)) - 32'd1;

	logic [ots_pkg::DIV_X_W-1:0]     div_x;
	logic [2*ots_pkg::DIV_X_W-1:0]   div_prod;
	logic [31:0]                     quotient;
	logic [31:0]                     raw;

	// Product / 180 = (product / 4) / 45, by reciprocal multiplication.
	assign div_x    = product[31:2];
	assign div_prod = (2*ots_pkg::DIV_X_W)'(div_x) * (2*ots_pkg::DIV_X_W)'(ots_pkg::DIV_MULT);
	assign quotient = 32'(div_prod >> ots_pkg::DIV_SHIFT);

	// Saturate the magnitude at the largest positive odometer value.
	assign raw    = by_degrees ? quotient : {16'd0, mag};
	assign target = (raw > ODO_MAX) ? ODO_MAX[ODO_WIDTH-2:0] : raw[ODO_WIDTH-2:0];

endmodule

/* design/odometry_turn_sequencer.sv */
// Top level of the odometry turn sequencer.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    action, turn_amount, turn_speed, commanded_speed,
//                                left_odometer
//   res      out  valid/ready    goals, write strobes, go flags, reset request, phase
//   cfg      in   cfg_we         cfg_idx, cfg_wdata (0 half_turn_count, 1 fwd speed)
//
// One word per cycle while res takes results. A command word is registered, then when
// the result register is free the sequencer updates its state and loads the result
// register, whose outputs drive res.
// The degree product is formed before the input register and divided by 180 after it,
// one multiplier per path.
// Reset clears the phase, counters, turn rate, target, reset request and both config
// registers.
// A stalled result holds the result register; the input register then holds
// one more word before cmd.ready drops.
module odometry_turn_sequencer #(
	parameter int STOP_SETTLE_TICKS = 200,
	parameter int PAUSE_TICKS       = 100,
	parameter int ODO_WIDTH         = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	ots_cmd_if.sink            cmd,
	ots_res_if.source          res,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [15:0]        cfg_wdata
);

	localparam int TW = ODO_WIDTH - 1;

	// Configuration registers.
	logic [15:0]        half_q;
	logic signed [15:0] fwd_q;

	// Sequencer state.
	logic [2:0]                        phase_q;
	logic [ots_pkg::SETTLE_W-1:0]      settle_q;
	logic [ots_pkg::PAUSE_W-1:0]       pause_q;
	logic signed [16:0]                rate_q;
	logic [TW-1:0]                     target_q;
	logic                              rstreq_q;

	// Input stage.
	logic                  valid_s1;
	logic [1:0]            action_s1;
	logic                  pos_s1;
	logic [15:0]           mag_s1;
	logic [15:0]           speed_s1;
	logic                  cmd_zero_s1;
	logic [ODO_WIDTH-1:0]  aodo_s1;
	logic [31:0]           prod_s1;

	// Result stage.
	logic               valid_s2;
	logic               aw_s2;
	logic signed [16:0] ag_s2;
	logic               lw_s2;
	logic signed [15:0] lg_s2;
	logic               hold_s2;
	logic               rel_s2;
	logic               rstreq_s2;
	logic               busy_s2;
	logic               rej_s2;
	logic [2:0]         phase_s2;

	// Input-side helpers.
	logic [15:0]           mag_in;
	logic [ODO_WIDTH-1:0]  odo_in;
	logic [ODO_WIDTH-1:0]  aodo_in;
	logic [31:0]           prod_in;
	logic                  advance;
	logic                  accept;

	// Next-state and result values.
	logic [2:0]                   phase_n;
	logic [ots_pkg::SETTLE_W-1:0] settle_n;
	logic [ots_pkg::PAUSE_W-1:0]  pause_n;
	logic signed [16:0]           rate_n;
	logic [TW-1:0]                target_n;
	logic                         rstreq_n;
	logic                         aw_n;
	logic signed [16:0]           ag_n;
	logic                         lw_n;
	logic signed [15:0]           lg_n;
	logic                         hold_n;
	logic                         rel_n;
	logic                         rej_n;
	logic [TW-1:0]                start_target;
	logic signed [16:0]           start_rate;
	logic [ots_pkg::SETTLE_W-1:0] settle_inc;
	logic [ots_pkg::PAUSE_W-1:0]  pause_inc;

	// Handshake: the input stage moves on when the result register is free.
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign accept    = cmd.valid && cmd.ready;

	// Magnitudes and the degree product, formed ahead of the input register.
	assign mag_in  = cmd.turn_amount[15] ? 16'(-cmd.turn_amount) : 16'(cmd.turn_amount);
	assign odo_in  = cmd.left_odometer;
	assign aodo_in = odo_in[ODO_WIDTH-1] ? (~odo_in + ODO_WIDTH'(1)) : odo_in;
	assign prod_in = 32'(mag_in) * 32'(half_q);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= '0;
			fwd_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				ots_pkg::CFG_HALF_TURN: half_q <= cfg_wdata;
				ots_pkg::CFG_FWD_SPEED: fwd_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= cmd.action;
			pos_s1      <= !cmd.turn_amount[15] && (cmd.turn_amount != 16'sd0);
			mag_s1      <= mag_in;
			speed_s1    <= cmd.turn_speed;
			cmd_zero_s1 <= (cmd.commanded_speed == 16'sd0);
			aodo_s1     <= aodo_in;
			prod_s1     <= prod_in;
		end
	end

	// Target for either start command.
	ots_target #(
		.ODO_WIDTH (ODO_WIDTH)
	) u_target (
		.by_degrees (action_s1 == ots_pkg::ACT_START_DEG),
		.mag        (mag_s1),
		.product    (prod_s1),
		.target     (start_target)
	);

	assign start_rate = pos_s1 ? $signed({1'b0, speed_s1}) : -$signed({1'b0, speed_s1});
	assign settle_inc = (settle_q == ots_pkg::SETTLE_FULL) ? settle_q
	                                                      : settle_q + ots_pkg::SETTLE_W'(1);
	assign pause_inc  = (pause_q == ots_pkg::PAUSE_FULL) ? pause_q
	                                                    : pause_q + ots_pkg::PAUSE_W'(1);

	// Sequencer step for the word in the input register.
	always_comb begin
		phase_n  = phase_q;
		settle_n = settle_q;
		pause_n  = pause_q;
		rate_n   = rate_q;
		target_n = target_q;
		rstreq_n = rstreq_q;
		aw_n     = 1'b0;
		ag_n     = '0;
		lw_n     = 1'b0;
		lg_n     = '0;
		hold_n   = 1'b0;
		rel_n    = 1'b0;
		rej_n    = 1'b0;
		case (action_s1)
			ots_pkg::ACT_START_CNT: begin
				if (mag_s1 == 16'd0) begin
					rej_n = 1'b1;
				end else begin
					rate_n   = start_rate;
					target_n = start_target;
					phase_n  = ots_pkg::PH_STOP_WAIT;
					pause_n  = '0;
				end
			end
			ots_pkg::ACT_START_DEG: begin
				rate_n   = start_rate;
				target_n = start_target;
				phase_n  = ots_pkg::PH_STOP_WAIT;
				pause_n  = '0;
			end
			ots_pkg::ACT_STOP: begin
				phase_n = ots_pkg::PH_IDLE;
				hold_n  = 1'b1;
			end
			default: begin
				case (phase_q)
					ots_pkg::PH_STOP_WAIT: begin
						hold_n = 1'b1;
						aw_n   = 1'b1;
						if (cmd_zero_s1) begin
							rstreq_n = 1'b1;
							settle_n = settle_inc;
							if (settle_q > ots_pkg::SETTLE_W'(STOP_SETTLE_TICKS) ||
							    settle_q == ots_pkg::SETTLE_FULL) begin
								phase_n  = ots_pkg::PH_RST_CHECK;
								settle_n = '0;
								rstreq_n = 1'b0;
							end
						end
					end
					ots_pkg::PH_RST_CHECK: begin
						if (aodo_s1 < ODO_WIDTH'(ots_pkg::RESET_NEAR_ZERO)) begin
							rstreq_n = 1'b0;
							phase_n  = ots_pkg::PH_PAUSE;
						end
					end
					ots_pkg::PH_PAUSE: begin
						aw_n    = 1'b1;
						pause_n = pause_inc;
						if (pause_q > ots_pkg::PAUSE_W'(PAUSE_TICKS) ||
						    pause_q == ots_pkg::PAUSE_FULL) begin
							phase_n = ots_pkg::PH_DRIVE;
						end
					end
					ots_pkg::PH_DRIVE: begin
						lw_n    = 1'b1;
						lg_n    = fwd_q;
						aw_n    = 1'b1;
						ag_n    = rate_q;
						phase_n = ots_pkg::PH_TURNING;
					end
					ots_pkg::PH_TURNING: begin
						if (aodo_s1 > {1'b0, target_q}) begin
							aw_n     = 1'b1;
							lw_n     = 1'b1;
							phase_n  = ots_pkg::PH_SETTLE;
							settle_n = '0;
						end
					end
					ots_pkg::PH_SETTLE: begin
						settle_n = settle_inc;
						if (settle_q > ots_pkg::AFTER_TURN_TICKS) begin
							phase_n = ots_pkg::PH_RELEASE;
						end
					end
					ots_pkg::PH_RELEASE: begin
						rel_n   = 1'b1;
						phase_n = ots_pkg::PH_IDLE;
					end
					default: ;
				endcase
			end
		endcase
	end

	// Sequencer state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ots_pkg::PH_IDLE;
			settle_q <= '0;
			pause_q  <= '0;
			rate_q   <= '0;
			target_q <= '0;
			rstreq_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_n;
			settle_q <= settle_n;
			pause_q  <= pause_n;
			rate_q   <= rate_n;
			target_q <= target_n;
			rstreq_q <= rstreq_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			aw_s2     <= aw_n;
			ag_s2     <= ag_n;
			lw_s2     <= lw_n;
			lg_s2     <= lg_n;
			hold_s2   <= hold_n;
			rel_s2    <= rel_n;
			rstreq_s2 <= rstreq_n;
			busy_s2   <= (phase_n != ots_pkg::PH_IDLE);
			rej_s2    <= rej_n;
			phase_s2  <= phase_n;
		end
	end

	assign res.valid          = valid_s2;
	assign res.angular_write  = aw_s2;
	assign res.angular_goal   = ag_s2;
	assign res.linear_write   = lw_s2;
	assign res.linear_goal    = lg_s2;
	assign res.go_hold        = hold_s2;
	assign res.go_release     = rel_s2;
	assign res.odometer_reset = rstreq_s2;
	assign res.busy_res       = busy_s2;
	assign res.start_rejected = rej_s2;
	assign res.phase          = phase_s2;

	// Releasing line following always ends the sequence.
	a_release_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rel_s2 |-> phase_s2 == ots_pkg::PH_IDLE)
		else $error("go_release with a phase other than idle");

	// A rejected start writes no goal and leaves the phase unchanged.
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rej_n |-> !aw_n && !lw_n && phase_n == phase_q)
		else $error("rejected start changed the sequence");

	// A linear goal is only ever written together with an angular goal.
	a_linear_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && lw_s2 |-> aw_s2)
		else $error("linear goal written without angular goal");

	// A word held in the input register is never dropped while the output stalls.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(action_s1))
		else $error("input register lost a stalled word");

endmodule

/* bench/odometry_turn_sequencer_tb.sv */
// Self-checking testbench for the odometry turn sequencer: turn sequences and noise words.
module odometry_turn_sequencer_tb;

	localparam int STOP_SETTLE_TICKS = 200;
	localparam int PAUSE_TICKS       = 100;
	localparam int ODO_W             = 24;
	localparam longint ODO_MAX       = (longint'(1) << (ODO_W - 1)) - 1;
	localparam longint DEG_HALF      = 180;
	localparam int IDLE_LIMIT        = 2000;
	localparam int HOLD_CYCLES       = 60;
	localparam int REPORT_MAX        = 10;
	localparam int SEQ_MAX_WORDS     = 470;

	typedef struct {
		logic [1:0]              action;
		logic signed [15:0]      turn_amount;
		logic [15:0]             turn_speed;
		logic signed [15:0]      commanded_speed;
		logic signed [ODO_W-1:0] left_odometer;
	} cmd_word_t;

	typedef struct {
		logic               angular_write;
		logic signed [16:0] angular_goal;
		logic               linear_write;
		logic signed [15:0] linear_goal;
		logic               go_hold;
		logic               go_release;
		logic               odometer_reset;
		logic               busy;
		logic               start_rejected;
		logic [2:0]         phase;
	} turn_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [15:0] cfg_wdata;

	ots_cmd_if #(.ODO_WIDTH(ODO_W)) cmd_ch ();
	ots_res_if res_ch ();

	odometry_turn_sequencer #(
		.STOP_SETTLE_TICKS(STOP_SETTLE_TICKS),
		.PAUSE_TICKS(PAUSE_TICKS),
		.ODO_WIDTH(ODO_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// Predicted sequencer state and its copy of the configuration.
	logic [2:0]                   seq_phase       = ots_pkg::PH_IDLE;
	logic [ots_pkg::SETTLE_W-1:0] settle_ticks    = '0;
	logic [ots_pkg::PAUSE_W-1:0]  pause_ticks     = '0;
	logic signed [16:0]           rate_goal       = '0;
	longint                       odo_target      = 0;
	logic                         odo_reset_level = 1'b0;
	logic [15:0]                  cfg_half_turn   = '0;
	logic [15:0]                  cfg_fwd_speed   = '0;

	cmd_word_t    cmd_backlog[$];
	turn_result_t pending_results[$];
	cmd_word_t    next_word;

	int   queued_count   = 0;
	int   accepted_count = 0;
	int   fail_count     = 0;
	int   idle_cycles    = 0;
	int   tx_gap         = 0;
	int   rx_stall       = 0;
	logic cmd_fire       = 1'b0;
	logic idle_on        = 1'b1;
	logic hold_trigger   = 1'b0;
	logic rx_hold_on     = 1'b0;

	// Sequence builder bookkeeping: position in the sequence and where it breaks off.
	int seq_pos;
	int seq_cut;
	bit seq_broken;

	function automatic longint clamp_target(longint m);
		return (m > ODO_MAX) ? ODO_MAX : m;
	endfunction

	// Advance the predicted sequencer by one accepted command word.
	function automatic turn_result_t step_turn_sequence(cmd_word_t w);
		turn_result_t                 r;
		longint                       mag;
		longint                       aodo;
		logic [ots_pkg::SETTLE_W-1:0] old_settle;
		logic [ots_pkg::PAUSE_W-1:0]  old_pause;
		r = '{default: 0};
		mag = (w.turn_amount < 0) ? -longint'(w.turn_amount) : longint'(w.turn_amount);
		aodo = (w.left_odometer < 0) ? -longint'(w.left_odometer) : longint'(w.left_odometer);
		case (w.action)
			ots_pkg::ACT_START_CNT: begin
				if (w.turn_amount == 0) begin
					r.start_rejected = 1'b1;
				end else begin
					rate_goal = (w.turn_amount > 0) ? int'(w.turn_speed) : -int'(w.turn_speed);
					odo_target = clamp_target(mag);
					seq_phase = ots_pkg::PH_STOP_WAIT;
					pause_ticks = '0;
				end
			end
			ots_pkg::ACT_START_DEG: begin
				rate_goal = (w.turn_amount > 0) ? int'(w.turn_speed) : -int'(w.turn_speed);
				odo_target = clamp_target(mag * longint'(cfg_half_turn) / DEG_HALF);
				seq_phase = ots_pkg::PH_STOP_WAIT;
				pause_ticks = '0;
			end
			ots_pkg::ACT_STOP: begin
				seq_phase = ots_pkg::PH_IDLE;
				r.go_hold = 1'b1;
			end
			default: begin
				case (seq_phase)
					ots_pkg::PH_STOP_WAIT: begin
						r.go_hold = 1'b1;
						r.angular_write = 1'b1;
						if (w.commanded_speed == 0) begin
							odo_reset_level = 1'b1;
							old_settle = settle_ticks;
							if (settle_ticks != ots_pkg::SETTLE_FULL)
								settle_ticks = settle_ticks + 1'b1;
							if (old_settle > STOP_SETTLE_TICKS ||
							    old_settle == ots_pkg::SETTLE_FULL) begin
								seq_phase = ots_pkg::PH_RST_CHECK;
								settle_ticks = '0;
								odo_reset_level = 1'b0;
							end
						end
					end
					ots_pkg::PH_RST_CHECK: begin
						if (aodo < ots_pkg::RESET_NEAR_ZERO) begin
							odo_reset_level = 1'b0;
							seq_phase = ots_pkg::PH_PAUSE;
						end
					end
					ots_pkg::PH_PAUSE: begin
						r.angular_write = 1'b1;
						old_pause = pause_ticks;
						if (pause_ticks != ots_pkg::PAUSE_FULL)
							pause_ticks = pause_ticks + 1'b1;
						if (old_pause > PAUSE_TICKS || old_pause == ots_pkg::PAUSE_FULL)
							seq_phase = ots_pkg::PH_DRIVE;
					end
					ots_pkg::PH_DRIVE: begin
						r.linear_write = 1'b1;
						r.linear_goal = cfg_fwd_speed;
						r.angular_write = 1'b1;
						r.angular_goal = rate_goal;
						seq_phase = ots_pkg::PH_TURNING;
					end
					ots_pkg::PH_TURNING: begin
						// Turn is complete once the wheel passes the target: both goals go to zero.
						if (aodo > odo_target) begin
							r.angular_write = 1'b1;
							r.linear_write = 1'b1;
							seq_phase = ots_pkg::PH_SETTLE;
							settle_ticks = '0;
						end
					end
					ots_pkg::PH_SETTLE: begin
						old_settle = settle_ticks;
						if (settle_ticks != ots_pkg::SETTLE_FULL)
							settle_ticks = settle_ticks + 1'b1;
						if (old_settle > ots_pkg::AFTER_TURN_TICKS)
							seq_phase = ots_pkg::PH_RELEASE;
					end
					ots_pkg::PH_RELEASE: begin
						r.go_release = 1'b1;
						seq_phase = ots_pkg::PH_IDLE;
					end
					default: ;
				endcase
			end
		endcase
		r.odometer_reset = odo_reset_level;
		r.busy = (seq_phase != ots_pkg::PH_IDLE);
		r.phase = seq_phase;
		return r;
	endfunction

	function automatic bit same_result(turn_result_t a, turn_result_t b);
		return a.angular_write === b.angular_write && a.angular_goal === b.angular_goal &&
			a.linear_write === b.linear_write && a.linear_goal === b.linear_goal &&
			a.go_hold === b.go_hold && a.go_release === b.go_release &&
			a.odometer_reset === b.odometer_reset && a.busy === b.busy &&
			a.start_rejected === b.start_rejected && a.phase === b.phase;
	endfunction

	function automatic string show_result(turn_result_t r);
		return $sformatf({"aw=%0d ag=%0d lw=%0d lg=%0d hold=%0d rel=%0d ",
			"orst=%0d busy=%0d rej=%0d ph=%0d"},
			r.angular_write, r.angular_goal, r.linear_write, r.linear_goal, r.go_hold,
			r.go_release, r.odometer_reset, r.busy, r.start_rejected, r.phase);
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Reset, with every input of the block at a known value from the start.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = ots_pkg::CFG_HALF_TURN;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ots_pkg::ACT_TICK;
		cmd_ch.turn_amount = '0;
		cmd_ch.turn_speed = '0;
		cmd_ch.commanded_speed = '0;
		cmd_ch.left_odometer = '0;
		res_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Command driver: presents the backlog one word at a time, with random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_fire) begin
			if (tx_gap > 0) begin
				cmd_ch.valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (cmd_backlog.size() > 0) begin
				next_word = cmd_backlog.pop_front();
				cmd_ch.action <= next_word.action;
				cmd_ch.turn_amount <= next_word.turn_amount;
				cmd_ch.turn_speed <= next_word.turn_speed;
				cmd_ch.commanded_speed <= next_word.commanded_speed;
				cmd_ch.left_odometer <= next_word.left_odometer;
				cmd_ch.valid <= 1'b1;
				if (idle_on && $urandom_range(0, 9) == 0)
					tx_gap <= $urandom_range(1, 7);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stall bursts, plus the long hold-off when it is running.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (rx_hold_on) begin
			res_ch.ready <= 1'b0;
		end else if (rx_stall > 0) begin
			res_ch.ready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			res_ch.ready <= 1'b1;
			if (idle_on && $urandom_range(0, 11) == 0)
				rx_stall <= $urandom_range(1, 7);
		end
	end

	// Long hold-off on the result side so the block fills up and stalls its input.
	initial begin
		wait (hold_trigger);
		@(negedge clk);
		rx_hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold_on <= 1'b0;
	end

	// Monitor: predict on each accepted command word, check each accepted result word.
	always @(posedge clk) begin : monitor
		cmd_word_t    w;
		turn_result_t got;
		turn_result_t want;
		if (arst_n) begin
			cmd_fire <= cmd_ch.valid && cmd_ch.ready;
			if (res_ch.valid && res_ch.ready) begin
				got.angular_write = res_ch.angular_write;
				got.angular_goal = res_ch.angular_goal;
				got.linear_write = res_ch.linear_write;
				got.linear_goal = res_ch.linear_goal;
				got.go_hold = res_ch.go_hold;
				got.go_release = res_ch.go_release;
				got.odometer_reset = res_ch.odometer_reset;
				got.busy = res_ch.busy_res;
				got.start_rejected = res_ch.start_rejected;
				got.phase = res_ch.phase;
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected result word: %s", show_result(got));
				end else begin
					want = pending_results.pop_front();
					if (!same_result(want, got)) begin
						fail_count++;
						if (fail_count <= REPORT_MAX) begin
							$display("result mismatch");
							$display("  expected %s", show_result(want));
							$display("  actual   %s", show_result(got));
						end
					end
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				w.action = cmd_ch.action;
				w.turn_amount = cmd_ch.turn_amount;
				w.turn_speed = cmd_ch.turn_speed;
				w.commanded_speed = cmd_ch.commanded_speed;
				w.left_odometer = cmd_ch.left_odometer;
				pending_results.push_back(step_turn_sequence(w));
				accepted_count++;
			end
			// Watchdog on cycles without any accepted word.
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[odometry_turn_sequencer] ERROR");
				$finish;
			end
		end
	end

	task automatic push_word(logic [1:0] act, logic [15:0] amt, logic [15:0] spd,
			logic [15:0] cs, logic [ODO_W-1:0] odo);
		cmd_word_t w;
		w.action = act;
		w.turn_amount = amt;
		w.turn_speed = spd;
		w.commanded_speed = cs;
		w.left_odometer = odo;
		cmd_backlog.push_back(w);
		queued_count++;
	endtask

	function automatic logic [15:0] any16();
		return $urandom_range(0, 65535);
	endfunction

	function automatic logic [ODO_W-1:0] any_odo();
		logic [31:0] v;
		v = $urandom();
		return v[ODO_W-1:0];
	endfunction

	// Odometer value with the given magnitude and a random sign; the most negative code
	// is the only way to show a magnitude one past the positive range.
	function automatic logic [ODO_W-1:0] signed_odo(longint m);
		longint v;
		if (m > ODO_MAX)
			return {1'b1, {(ODO_W-1){1'b0}}};
		v = $urandom_range(0, 1) ? -m : m;
		return v[ODO_W-1:0];
	endfunction

	// Odometer value well away from zero, so a pending reset stays unconfirmed.
	function automatic logic [ODO_W-1:0] far_odo();
		logic signed [ODO_W-1:0] v;
		v = any_odo();
		if (v > -50 && v < 50)
			v = 4096;
		return v;
	endfunction

	function automatic logic [ODO_W-1:0] odo_up_to(longint lim);
		return signed_odo($urandom_range(0, (lim > 49) ? 49 : int'(lim)));
	endfunction

	task automatic write_cfg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		if (idx == ots_pkg::CFG_HALF_TURN)
			cfg_half_turn = val;
		else
			cfg_fwd_speed = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued word went in and every expected result came out.
	task automatic drain();
		while (accepted_count != queued_count || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic noise_word();
		logic [1:0] act;
		act = ($urandom_range(0, 9) < 6) ? ots_pkg::ACT_TICK : 2'($urandom_range(1, 3));
		push_word(act, any16(), any16(), any16(), any_odo());
	endtask

	// One tick of a turn sequence, or the word that breaks the sequence off.
	task automatic seq_tick(logic [15:0] cs, logic [ODO_W-1:0] odo);
		if (seq_broken)
			return;
		if (seq_pos == seq_cut) begin
			seq_broken = 1;
			if ($urandom_range(0, 1))
				push_word(ots_pkg::ACT_STOP, any16(), any16(), any16(), any_odo());
			else
				push_word($urandom_range(0, 1) ? ots_pkg::ACT_START_CNT
				                               : ots_pkg::ACT_START_DEG,
					any16(), any16(), any16(), any_odo());
		end else begin
			push_word(ots_pkg::ACT_TICK, any16(), any16(), cs, odo);
		end
		seq_pos++;
	endtask

	// A full turn: start, stop wait, reset check, pause, turn, settle, release.
	// A sequence that would not fit in the words left is broken off at the end of them.
	task automatic run_turn_sequence(int room);
		logic [15:0]  amt;
		logic [1:0]   act;
		longint       mag;
		longint       tgt;
		int           sel;
		seq_pos = 0;
		seq_broken = 0;
		seq_cut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 470) : -1;
		if (room < SEQ_MAX_WORDS && (seq_cut < 0 || seq_cut > room - 2))
			seq_cut = (room > 2) ? room - 2 : 0;
		act = $urandom_range(0, 1) ? ots_pkg::ACT_START_CNT : ots_pkg::ACT_START_DEG;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			amt = 16'h7FFF;
		else if (sel == 1)
			amt = 16'h8000;
		else if (sel < 4)
			amt = any16();
		else
			amt = $urandom_range(0, 1) ? 16'($urandom_range(1, 600))
			                           : -16'($urandom_range(1, 600));
		if (act == ots_pkg::ACT_START_CNT && amt == 0)
			act = ots_pkg::ACT_START_DEG;
		mag = ($signed(amt) < 0) ? -longint'($signed(amt)) : longint'($signed(amt));
		tgt = (act == ots_pkg::ACT_START_CNT) ? mag
		                                      : clamp_target(mag * longint'(cfg_half_turn) / DEG_HALF);
		push_word(act, amt, any16(), any16(), any_odo());
		// Speed command mostly at zero so the stop wait runs out.
		repeat (230)
			seq_tick(($urandom_range(0, 19) == 0) ? any16() : 16'd0, far_odo());
		// Odometer reset confirmed after a few readings.
		repeat ($urandom_range(1, 4))
			seq_tick(any16(), far_odo());
		repeat (5)
			seq_tick(any16(), signed_odo($urandom_range(0, 49)));
		// Pause, with the odometer still short of the target.
		repeat (105)
			seq_tick(any16(), odo_up_to(tgt));
		for (int k = 1; k <= 12; k++)
			seq_tick(any16(), signed_odo(tgt * k / 12));
		repeat ($urandom_range(1, 3))
			seq_tick(any16(), signed_odo(tgt + 1 + $urandom_range(0, 20)));
		// Settle and release.
		repeat (108)
			seq_tick(any16(), any_odo());
	endtask

	task automatic random_stretch(int budget);
		int first;
		first = queued_count;
		while (queued_count - first < budget) begin
			if ($urandom_range(0, 3) != 0)
				run_turn_sequence(budget - (queued_count - first));
			else
				repeat ($urandom_range(1, 12)) noise_word();
		end
	endtask

	// Stimulus: directed words, then random stretches under several register settings.
	initial begin
		wait (arst_n === 1'b1);
		write_cfg(ots_pkg::CFG_HALF_TURN, 16'd360);
		write_cfg(ots_pkg::CFG_FWD_SPEED, 16'd120);
		@(posedge clk);
		push_word(ots_pkg::ACT_TICK, 16'h8000, 16'hFFFF, 16'h8000, 24'h800000);
		push_word(ots_pkg::ACT_TICK, 16'h7FFF, 16'h0000, 16'h7FFF, 24'h7FFFFF);
		push_word(ots_pkg::ACT_START_CNT, 16'd0, 16'd500, 16'd0, 24'd0);
		push_word(ots_pkg::ACT_START_DEG, 16'd0, 16'd1234, 16'd0, 24'd0);
		push_word(ots_pkg::ACT_TICK, 16'd0, 16'd0, 16'd5, 24'd0);
		push_word(ots_pkg::ACT_TICK, 16'd0, 16'd0, 16'd0, 24'd0);
		push_word(ots_pkg::ACT_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		push_word(ots_pkg::ACT_TICK, 16'd0, 16'd0, 16'd0, 24'd10);
		push_word(ots_pkg::ACT_START_CNT, 16'h7FFF, 16'hFFFF, 16'd3, 24'd0);
		push_word(ots_pkg::ACT_TICK, 16'd0, 16'd0, 16'd0, 24'd100);
		push_word(ots_pkg::ACT_START_CNT, 16'h8000, 16'hFFFF, 16'd0, 24'd0);
		push_word(ots_pkg::ACT_TICK, 16'd0, 16'd0, 16'hFFFF, 24'd0);
		push_word(ots_pkg::ACT_START_DEG, 16'h7FFF, 16'd0, 16'd0, 24'd0);
		push_word(ots_pkg::ACT_START_DEG, 16'h8000, 16'hFFFF, 16'd0, 24'd0);
		repeat (3) push_word(ots_pkg::ACT_TICK, 16'd0, 16'd0, 16'd0, 24'h800000);
		push_word(ots_pkg::ACT_STOP, 16'd0, 16'd0, 16'd0, 24'd0);
		push_word(ots_pkg::ACT_STOP, 16'd0, 16'd0, 16'd0, 24'd0);
		push_word(ots_pkg::ACT_START_CNT, 16'd1, 16'd1, 16'd0, 24'd0);
		push_word(ots_pkg::ACT_TICK, 16'd0, 16'd0, 16'd0, 24'd0);
		push_word(ots_pkg::ACT_STOP, 16'd0, 16'd0, 16'd0, 24'd0);
		drain();

		// Largest half turn: degree targets reach the odometer range limit.
		write_cfg(ots_pkg::CFG_HALF_TURN, 16'hFFFF);
		write_cfg(ots_pkg::CFG_FWD_SPEED, 16'h8000);
		@(posedge clk);
		random_stretch(300);
		hold_trigger = 1'b1;
		drain();

		write_cfg(ots_pkg::CFG_HALF_TURN, 16'd0);
		write_cfg(ots_pkg::CFG_FWD_SPEED, 16'h7FFF);
		@(posedge clk);
		random_stretch(100);
		drain();

		// Last stretch at full rate on both sides, long enough for a whole turn.
		write_cfg(ots_pkg::CFG_HALF_TURN, 16'($urandom_range(1, 65534)));
		write_cfg(ots_pkg::CFG_FWD_SPEED, any16());
		@(posedge clk);
		idle_on = 1'b0;
		random_stretch(480);
		drain();

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("[odometry_turn_sequencer] OK");
		else
			$display("[odometry_turn_sequencer] ERROR");
		$finish;
	end

endmodule
